// ===== rtl/core/expression_char_tokenizer_top_defines.svh =====
// Assertion macros used by the expression tokenizer back end.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef EXPRESSION_CHAR_TOKENIZER_TOP_DEFINES_SVH
`define EXPRESSION_CHAR_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ETOK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ETOK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/etok_pkg.sv =====
// Types, codes and helper functions of the expression tokenizer.
// No dependencies; used by the front, back and top modules.
package etok_pkg;

    localparam int POS_BITS = 16;
    localparam int EPOS_W   = 16;
    localparam int QCNT_W   = 2;
    localparam logic [QCNT_W-1:0] QDEPTH = 2'd2;

    typedef enum logic [3:0] {
        CLS_SPACE,
        CLS_LT,
        CLS_MINUS,
        CLS_HASH,
        CLS_DOT,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_COMMA,
        CLS_DIGIT,
        CLS_LETTER,
        CLS_OTHER
    } t_cls;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_LT,
        MODE_VAR,
        MODE_NUM,
        MODE_FUNC
    } t_mode;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_ARROW = 3'd1;
    localparam logic [2:0] KIND_OPEN  = 3'd2;
    localparam logic [2:0] KIND_CLOSE = 3'd3;
    localparam logic [2:0] KIND_COMMA = 3'd4;
    localparam logic [2:0] KIND_VAR   = 3'd5;
    localparam logic [2:0] KIND_NUM   = 3'd6;
    localparam logic [2:0] KIND_FUNC  = 3'd7;

    typedef struct packed {
        t_cls cls;
        logic last;
    } t_cls_item;

    typedef struct packed {
        logic [2:0]        kind;
        logic              start;
        logic              err;
        logic [EPOS_W-1:0] epos;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [2:0] kind;
        logic       start;
        t_mode      mode;
        logic       err;
    } t_begin;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls cls;
        if (c == 8'h20) cls = CLS_SPACE;
        else if (c == 8'h3C) cls = CLS_LT;
        else if (c == 8'h2D) cls = CLS_MINUS;
        else if (c == 8'h23) cls = CLS_HASH;
        else if (c == 8'h2E) cls = CLS_DOT;
        else if (c == 8'h28) cls = CLS_OPEN;
        else if (c == 8'h29) cls = CLS_CLOSE;
        else if (c == 8'h2C) cls = CLS_COMMA;
        else if (c inside {[8'h30:8'h39]}) cls = CLS_DIGIT;
        else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) cls = CLS_LETTER;
        else cls = CLS_OTHER;
        return cls;
    endfunction

    // Token opened by a character from the between-tokens position.
    function automatic t_begin begin_token(input t_cls cls);
        t_begin b;
        b.kind  = KIND_NONE;
        b.start = 1'b1;
        b.mode  = MODE_IDLE;
        b.err   = 1'b0;
        case (cls)
            CLS_SPACE: b.start = 1'b0;
            CLS_LT: begin
                b.kind = KIND_ARROW;
                b.mode = MODE_LT;
            end
            CLS_OPEN:  b.kind = KIND_OPEN;
            CLS_CLOSE: b.kind = KIND_CLOSE;
            CLS_COMMA: b.kind = KIND_COMMA;
            CLS_HASH: begin
                b.kind = KIND_VAR;
                b.mode = MODE_VAR;
            end
            CLS_MINUS, CLS_DIGIT: begin
                b.kind = KIND_NUM;
                b.mode = MODE_NUM;
            end
            CLS_LETTER: begin
                b.kind = KIND_FUNC;
                b.mode = MODE_FUNC;
            end
            default: b.err = 1'b1;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/etok_front.sv =====
// Front end: classifies each incoming character and queues it for the back end.
// Depends on etok_pkg.
module etok_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_char_in,
    input  logic               i_last_char,
    output logic               o_cls_empty,
    output etok_pkg::t_cls_item o_cls_item,
    input  logic               i_cls_pop
);
    import etok_pkg::*;

    t_cls_item           r_mem [QDEPTH];
    logic                r_wptr, n_wptr;
    logic                r_rptr, n_rptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                wr_en, rd_en;

    assign full        = (r_count == QDEPTH);
    assign o_cls_empty = (r_count == '0);
    assign wr_en       = push && !full;
    assign rd_en       = i_cls_pop && !o_cls_empty;
    assign o_cls_item  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = wr_en ? ~r_wptr : r_wptr;
        n_rptr  = rd_en ? ~r_rptr : r_rptr;
        n_count = r_count + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= '{cls: classify(i_char_in), last: i_last_char};
        end
    end

endmodule

// ===== rtl/core/etok_back.sv =====
// Back end: token state machine over classified characters, with a result queue.
// Depends on etok_pkg and the assertion macros header.
`include "expression_char_tokenizer_top_defines.svh"

module etok_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cls_empty,
    input  etok_pkg::t_cls_item i_cls_item,
    output logic                o_cls_pop,
    output logic                empty,
    input  logic                pop,
    output etok_pkg::t_result   o_result
);
    import etok_pkg::*;

    t_mode               r_mode, n_mode;
    logic                r_seen_dot, n_seen_dot;
    logic                r_ends_dot, n_ends_dot;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic                r_err_latched, n_err_latched;

    t_result             r_mem [QDEPTH];
    logic                r_wptr, r_rptr;
    logic [QCNT_W-1:0]   r_count;

    logic                out_full, step, rd_en;
    t_begin              bt;
    t_result             res;
    logic                tok_err, end_err;
    logic [2:0]          tok_kind;
    logic                tok_start;
    t_mode               tok_mode;
    logic                tok_seen, tok_ends;

    assign out_full  = (r_count == QDEPTH);
    assign empty     = (r_count == '0);
    assign step      = !i_cls_empty && !out_full;
    assign o_cls_pop = step;
    assign rd_en     = pop && !empty;
    assign o_result  = r_mem[r_rptr];
    assign bt        = begin_token(i_cls_item.cls);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_seen_dot    <= 1'b0;
            r_ends_dot    <= 1'b0;
            r_pos         <= '0;
            r_err_latched <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_seen_dot    <= n_seen_dot;
            r_ends_dot    <= n_ends_dot;
            r_pos         <= n_pos;
            r_err_latched <= n_err_latched;
        end
    end

    always_comb begin
        tok_kind  = KIND_NONE;
        tok_start = 1'b0;
        tok_err   = 1'b0;
        tok_mode  = r_mode;
        tok_seen  = r_seen_dot;
        tok_ends  = r_ends_dot;

        case (r_mode)
            MODE_LT: begin
                if (i_cls_item.cls == CLS_MINUS) begin
                    tok_kind = KIND_ARROW;
                    tok_mode = MODE_IDLE;
                end else begin
                    tok_err = 1'b1;
                end
            end
            MODE_VAR: begin
                if (i_cls_item.cls == CLS_DIGIT) begin
                    tok_kind = KIND_VAR;
                end else begin
                    tok_kind  = bt.kind;
                    tok_start = bt.start;
                    tok_err   = bt.err;
                    tok_mode  = bt.mode;
                end
            end
            MODE_NUM: begin
                if (i_cls_item.cls == CLS_DIGIT) begin
                    tok_kind = KIND_NUM;
                    tok_ends = 1'b0;
                end else if (i_cls_item.cls == CLS_DOT) begin
                    if (r_seen_dot) begin
                        tok_err = 1'b1;
                    end else begin
                        tok_kind = KIND_NUM;
                        tok_seen = 1'b1;
                        tok_ends = 1'b1;
                    end
                end else if (r_ends_dot || i_cls_item.cls == CLS_MINUS
                             || i_cls_item.cls == CLS_LETTER) begin
                    tok_err = 1'b1;
                end else begin
                    tok_kind  = bt.kind;
                    tok_start = bt.start;
                    tok_err   = bt.err;
                    tok_mode  = bt.mode;
                end
            end
            MODE_FUNC: begin
                if (i_cls_item.cls == CLS_LETTER || i_cls_item.cls == CLS_DIGIT) begin
                    tok_kind = KIND_FUNC;
                end else if (i_cls_item.cls == CLS_HASH) begin
                    tok_err = 1'b1;
                end else begin
                    tok_kind  = bt.kind;
                    tok_start = bt.start;
                    tok_err   = bt.err;
                    tok_mode  = bt.mode;
                end
            end
            default: begin
                tok_kind  = bt.kind;
                tok_start = bt.start;
                tok_err   = bt.err;
                tok_mode  = bt.mode;
            end
        endcase

        // a fresh number starts with no dot
        if (r_mode != MODE_NUM && tok_mode == MODE_NUM) begin
            tok_seen = 1'b0;
            tok_ends = 1'b0;
        end
        if (r_mode == MODE_NUM && tok_mode == MODE_NUM && tok_start) begin
            tok_seen = 1'b0;
            tok_ends = 1'b0;
        end

        // unfinished arrow or trailing dot at end of string
        end_err = !tok_err && i_cls_item.last
                  && (tok_mode == MODE_LT || (tok_mode == MODE_NUM && tok_ends));

        res.last = i_cls_item.last;
        if (r_err_latched) begin
            res.kind  = KIND_NONE;
            res.start = 1'b0;
            res.err   = 1'b0;
            res.epos  = '0;
        end else if (tok_err || end_err) begin
            res.kind  = KIND_NONE;
            res.start = 1'b0;
            res.err   = 1'b1;
            res.epos  = end_err ? EPOS_W'(r_pos + POS_BITS'(1)) : EPOS_W'(r_pos);
        end else begin
            res.kind  = tok_kind;
            res.start = tok_start;
            res.err   = 1'b0;
            res.epos  = '0;
        end

        n_mode        = r_mode;
        n_seen_dot    = r_seen_dot;
        n_ends_dot    = r_ends_dot;
        n_pos         = r_pos;
        n_err_latched = r_err_latched;
        if (step) begin
            if (i_cls_item.last) begin
                n_mode        = MODE_IDLE;
                n_seen_dot    = 1'b0;
                n_ends_dot    = 1'b0;
                n_pos         = '0;
                n_err_latched = 1'b0;
            end else if (!r_err_latched) begin
                n_mode        = tok_mode;
                n_seen_dot    = tok_seen;
                n_ends_dot    = tok_ends;
                n_pos         = r_pos + POS_BITS'(1);
                n_err_latched = tok_err;
            end
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (step) r_wptr <= ~r_wptr;
            if (rd_en) r_rptr <= ~r_rptr;
            r_count <= r_count + QCNT_W'(step) - QCNT_W'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_mem[r_wptr] <= res;
        end
    end

    `ETOK_ASSERT_NOW(a_err_clears_kind, step && res.err,
        res.kind == KIND_NONE && !res.start, "error result carries a token kind")
    `ETOK_ASSERT_NOW(a_quiet_after_err, step && r_err_latched,
        !res.err && res.epos == '0, "error reported while input is ignored")
    `ETOK_ASSERT_NOW(a_count_bound, 1'b1, r_count <= QDEPTH, "result queue overflow")
    `ETOK_ASSERT_NEXT(a_last_clears, step && i_cls_item.last,
        r_pos == '0 && !r_err_latched && r_mode == MODE_IDLE,
        "string state not cleared after last character")

endmodule

// ===== rtl/core/expression_char_tokenizer_top.sv =====
// Expression character tokenizer, one character in and one result out per word.
// Channels: input queue with push/full; result queue with empty/pop.
// Each accepted character gives exactly one result word: token kind, token
// start mark, error flag with position, and the echoed last flag.
// A character is classified as it enters the front queue; one step of the
// token state machine then writes its result into the result queue, from
// which it shows on the result ports.
// Throughput: one character per cycle while the receiver pops results;
// both queues hold two words, so streaming keeps full low.
// Reset: synchronous, active low; clears both queues and the string state.
// Receiver stall: results collect in the result queue; once it fills the
// state machine holds, the front queue fills, and full rises.
// After an error the rest of the string up to the last flag gives empty
// results; the last flag always returns the state to the start of a string.
// Depends on etok_pkg, etok_front and etok_back.
module expression_char_tokenizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_in,
    input  logic        i_last_char,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_token_kind,
    output logic        o_token_start,
    output logic        o_error_flag,
    output logic [15:0] o_error_pos,
    output logic        o_last_out
);
    import etok_pkg::*;

    logic      cls_empty;
    logic      cls_pop;
    t_cls_item cls_item;
    t_result   result;

    etok_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_char_in   (i_char_in),
        .i_last_char (i_last_char),
        .o_cls_empty (cls_empty),
        .o_cls_item  (cls_item),
        .i_cls_pop   (cls_pop)
    );

    etok_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_empty (cls_empty),
        .i_cls_item  (cls_item),
        .o_cls_pop   (cls_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result)
    );

    assign o_token_kind  = result.kind;
    assign o_token_start = result.start;
    assign o_error_flag  = result.err;
    assign o_error_pos   = result.epos;
    assign o_last_out    = result.last;

endmodule
